// ===== hdl/rth_pkg.sv =====
// Shared widths and sector codes for the RGB to hue fraction pipeline.
package rth_pkg;

  // Width of one color channel.
  localparam int unsigned CH_W = 8;
  // Width of the hue fraction, which is also the number of quotient bits.
  localparam int unsigned HUE_W = 16;
  // Signed width of the in-sector numerator (difference of two channels).
  localparam int unsigned NUM_W = CH_W + 1;
  // Width that holds 6 * (max - min) and the wrapped sector position.
  localparam int unsigned REM_W = CH_W + 3;
  // Front stages: min/max/sector, then position and divisor.
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned NUM_STAGES = FRONT_STAGES + HUE_W;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } hue_sector_t;

endpackage

// ===== hdl/rgb_to_hue_fraction.sv =====
// Pipelined RGB to HSV hue converter, hue given as a 16-bit fraction of a turn.
//
// Usage: each input word carries one 8-bit RGB pixel on in_red, in_green and
// in_blue; it is taken at a rising edge where in_valid is high and in_stall is
// low. Each pixel gives exactly one output word: out_hue_fraction, the hue
// times 65536 truncated, and out_is_grey, set when all channels are equal (the
// hue is then 0). Words leave in the order they came in.
// The stages in order: one stage finds the
// maximum, minimum and sector, one forms the wrapped sector position and the
// divisor 6 * (max - min), and 16 restoring-division stages produce one
// quotient bit each. Throughput is one pixel per cycle while out_stall is low.
// When out_stall holds the output word, stages behind it keep moving until
// they reach a full stage; in_stall rises only when every stage is occupied,
// so bubbles are squeezed out and nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties all stages; out_valid is low after it.
module rgb_to_hue_fraction (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rth_pkg::CH_W-1:0]  in_red,
  input  logic [rth_pkg::CH_W-1:0]  in_green,
  input  logic [rth_pkg::CH_W-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rth_pkg::HUE_W-1:0] out_hue_fraction,
  output logic                      out_is_grey
);

  localparam int unsigned NS = rth_pkg::NUM_STAGES;
  localparam int unsigned QW = rth_pkg::HUE_W;
  localparam int unsigned RW = rth_pkg::REM_W;
  localparam int unsigned CW = rth_pkg::CH_W;
  localparam int unsigned NW = rth_pkg::NUM_W;

  // Stage occupancy and per-stage load enables.
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] en;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !en[0];

  // Stage 1: maximum, minimum, sector of the maximum and in-sector numerator.
  logic [CW-1:0]            s1_mx_r, s1_mx_nxt;
  logic [CW-1:0]            s1_mn_r, s1_mn_nxt;
  rth_pkg::hue_sector_t     s1_sec_r, s1_sec_nxt;
  logic signed [NW-1:0]     s1_num_r, s1_num_nxt;

  always_comb begin
    s1_mx_nxt = in_red;
    s1_mn_nxt = in_red;
    if (in_green > s1_mx_nxt) begin
      s1_mx_nxt = in_green;
    end
    if (in_blue > s1_mx_nxt) begin
      s1_mx_nxt = in_blue;
    end
    if (in_green < s1_mn_nxt) begin
      s1_mn_nxt = in_green;
    end
    if (in_blue < s1_mn_nxt) begin
      s1_mn_nxt = in_blue;
    end
    // Ties for the maximum favor red, then green.
    if (in_red >= in_green && in_red >= in_blue) begin
      s1_sec_nxt = rth_pkg::SEC_RED;
      s1_num_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      s1_sec_nxt = rth_pkg::SEC_GREEN;
      s1_num_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      s1_sec_nxt = rth_pkg::SEC_BLUE;
      s1_num_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mx_r  <= s1_mx_nxt;
      s1_mn_r  <= s1_mn_nxt;
      s1_sec_r <= s1_sec_nxt;
      s1_num_r <= s1_num_nxt;
    end
  end

  // Stage 2: position on the turn in units of d, wrapped into 0..6d-1.
  logic [RW-1:0]   s2_x_r, s2_x_nxt;
  logic [RW-1:0]   s2_div_r, s2_div_nxt;
  logic            s2_grey_r, s2_grey_nxt;
  logic [CW-1:0]   s2_d;
  logic [RW-1:0]   s2_base;
  logic signed [RW:0] s2_pos;
  logic signed [RW:0] s2_wrap;

  always_comb begin
    s2_d        = s1_mx_r - s1_mn_r;
    s2_div_nxt  = {1'b0, s2_d, 2'b00} + {2'b00, s2_d, 1'b0};
    s2_grey_nxt = (s1_mx_r == s1_mn_r);
    case (s1_sec_r)
      rth_pkg::SEC_RED:   s2_base = '0;
      rth_pkg::SEC_GREEN: s2_base = {2'b00, s2_d, 1'b0};
      rth_pkg::SEC_BLUE:  s2_base = {1'b0, s2_d, 2'b00};
      default:            s2_base = '0;
    endcase
    s2_pos  = $signed({1'b0, s2_base}) + $signed({{(RW + 1 - NW){s1_num_r[NW-1]}}, s1_num_r});
    // Only the red sector can go negative; one turn brings it back.
    s2_wrap = s2_pos[RW] ? (s2_pos + $signed({1'b0, s2_div_nxt})) : s2_pos;
    s2_x_nxt = s2_wrap[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_x_r    <= s2_x_nxt;
      s2_div_r  <= s2_div_nxt;
      s2_grey_r <= s2_grey_nxt;
    end
  end

  // Division stages: restoring division of x * 2^16 by 6d, one quotient bit
  // per stage. Since x < 6d the quotient fits in 16 bits.
  logic [RW-1:0] rem_r  [QW];
  logic [RW-1:0] dv_r   [QW];
  logic [QW-1:0] quo_r  [QW];
  logic          grey_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] rem_in;
    logic [RW-1:0] dv_in;
    logic [QW-1:0] quo_in;
    logic          grey_in;
    logic [RW:0]   rem2;
    logic          qbit;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = s2_x_r;
      assign dv_in   = s2_div_r;
      assign quo_in  = '0;
      assign grey_in = s2_grey_r;
    end else begin : g_rest
      assign rem_in  = rem_r[j-1];
      assign dv_in   = dv_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign grey_in = grey_r[j-1];
    end

    always_comb begin
      rem2 = {rem_in, 1'b0};
      qbit = (rem2 >= {1'b0, dv_in});
      if (qbit) begin
        rem_nxt = RW'(rem2 - {1'b0, dv_in});
      end else begin
        rem_nxt = rem2[RW-1:0];
      end
      quo_nxt = {quo_in[QW-2:0], qbit};
      // A grey pixel has no hue; the last stage forces it to zero.
      if (j == QW - 1 && grey_in) begin
        quo_nxt = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en[rth_pkg::FRONT_STAGES + j]) begin
        rem_r[j]  <= rem_nxt;
        dv_r[j]   <= dv_in;
        quo_r[j]  <= quo_nxt;
        grey_r[j] <= grey_in;
      end
    end
  end

  assign out_valid        = vld_r[NS-1];
  assign out_hue_fraction = quo_r[QW-1];
  assign out_is_grey      = grey_r[QW-1];

  // The input side only waits when the whole pipeline is backed up.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&vld_r)))
    else $error("input stalled while the pipeline had room");

  // Grey words always leave with a zero hue.
  a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_grey) |-> (out_hue_fraction == '0))
    else $error("grey word with nonzero hue");

  // The wrapped position must be below the divisor or the quotient overflows.
  a_pos_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !s2_grey_r) |-> (s2_x_r < s2_div_r))
    else $error("sector position outside one turn");

endmodule

// ===== verif/rgb_to_hue_fraction_tb.sv =====
// Self-checking testbench for the RGB to hue fraction pipeline.
`timescale 1ns / 100ps

module rgb_to_hue_fraction_tb;

  localparam int unsigned CH_W = rth_pkg::CH_W;
  localparam int unsigned HUE_W = rth_pkg::HUE_W;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_PERCENT = 32;
  localparam int unsigned HOLDOFF_CYCLES = 80;
  localparam int unsigned HOLDOFF_AT = 200;
  localparam int unsigned RANDOM_PIXELS = 830;
  localparam int unsigned FIRST_BATCH = 400;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic             grey;
  } hue_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CH_W-1:0]   in_red = '0;
  logic [CH_W-1:0]   in_green = '0;
  logic [CH_W-1:0]   in_blue = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [HUE_W-1:0]  out_hue_fraction;
  logic              out_is_grey;

  pixel_t      pending_pixels[$];
  hue_word_t   expected_hues[$];
  int unsigned pixels_sent = 0;
  int unsigned hues_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  rgb_to_hue_fraction DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hue_fraction (out_hue_fraction),
    .out_is_grey      (out_is_grey)
  );

  always #10 clk = ~clk;

  // Hue of one pixel as a fraction of a turn, in exact integer arithmetic.
  function automatic hue_word_t predict_hue(input logic [CH_W-1:0] r, g, b);
    int                   hi;
    int                   lo;
    int                   span;
    int                   pos;
    rth_pkg::hue_sector_t sector;
    hue_word_t            res;
    hi = int'(r);
    lo = int'(r);
    if (int'(g) > hi) hi = int'(g);
    if (int'(b) > hi) hi = int'(b);
    if (int'(g) < lo) lo = int'(g);
    if (int'(b) < lo) lo = int'(b);
    span = hi - lo;
    res.hue = '0;
    res.grey = 1'b0;
    if (span == 0) begin
      res.grey = 1'b1;
    end else begin
      // Ties for the maximum go to red first, then green.
      if (r >= g && r >= b) sector = rth_pkg::SEC_RED;
      else if (g >= b) sector = rth_pkg::SEC_GREEN;
      else sector = rth_pkg::SEC_BLUE;
      case (sector)
        rth_pkg::SEC_RED:   pos = int'(g) - int'(b);
        rth_pkg::SEC_GREEN: pos = 2 * span + int'(b) - int'(r);
        default:            pos = 4 * span + int'(r) - int'(g);
      endcase
      // Magenta-side reds come out negative and wrap to the top of the turn.
      if (pos < 0) pos += 6 * span;
      res.hue = HUE_W'((pos * 65536) / (6 * span));
    end
    return res;
  endfunction

  // Sender: a word stays on the port until taken; idling is decided only
  // when no word is waiting.
  always @(posedge clk) begin : drive_pixels
    pixel_t nxt;
    bit     calm;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_hues.push_back(predict_hue(in_red, in_green, in_blue));
        pixels_sent++;
      end
      if (!in_valid || !in_stall) begin
        calm = (pixels_sent >= 500 && pixels_sent < 650);
        if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          nxt = pending_pixels.pop_front();
          in_red   <= nxt.red;
          in_green <= nxt.green;
          in_blue  <= nxt.blue;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word taken against the oldest prediction.
  always @(posedge clk) begin : watch_hues
    hue_word_t got;
    hue_word_t want;
    bit        calm;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.hue = out_hue_fraction;
        got.grey = out_is_grey;
        if (expected_hues.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual hue %h grey %b",
                   $time, got.hue, got.grey);
          error_count++;
        end else begin
          want = expected_hues.pop_front();
          if (got.hue != want.hue) begin
            $display("%0t: hue mismatch: expected %h, actual %h", $time, want.hue, got.hue);
            error_count++;
          end
          if (got.grey != want.grey) begin
            $display("%0t: grey flag mismatch: expected %b, actual %b",
                     $time, want.grey, got.grey);
            error_count++;
          end
        end
        hues_seen++;
      end
      calm = (hues_seen >= 520 && hues_seen < 680);
      // One long hold-off lets the pipeline fill and push back on the sender.
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (hues_seen == HOLDOFF_AT && !holdoff_done) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Checked at the falling edge, once the rising-edge updates have settled.
  task automatic wait_all_hues();
    while (pending_pixels.size() != 0 || in_valid || expected_hues.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    pixel_t          p;
    logic [CH_W-1:0] v;
    logic [CH_W-1:0] lo;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Greys, primaries, ties for the maximum, wrap-around reds, and spans of one.
    pending_pixels = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
      24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
      24'hFF0001, 24'hFF0100, 24'h010000, 24'h000100, 24'h000001,
      24'h00FF01, 24'h01FF00, 24'h0100FF, 24'h0001FF, 24'hFEFFFF,
      24'hFFFEFE, 24'hAA5500, 24'hC86432, 24'h55AAFF, 24'h7F807F
    };
    wait_all_hues();

    for (int k = 0; k < RANDOM_PIXELS; k++) begin
      // Let the sender sit until everything so far has come back.
      if (k == FIRST_BATCH) wait_all_hues();
      v = CH_W'($urandom_range(255));
      case ($urandom_range(9))
        0: p = {v, v, v};
        1: begin
          lo = CH_W'($urandom_range(v));
          case ($urandom_range(2))
            0:       p = {v, v, lo};
            1:       p = {v, lo, v};
            default: p = {lo, v, v};
          endcase
        end
        2: begin
          v = CH_W'($urandom_range(254));
          p = {v + CH_W'($urandom_range(1)), v + CH_W'($urandom_range(1)),
               v + CH_W'($urandom_range(1))};
        end
        default: p = 24'($urandom);
      endcase
      pending_pixels.push_back(p);
    end
    wait_all_hues();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rth_pkg.sv
hdl/rgb_to_hue_fraction.sv
verif/rgb_to_hue_fraction_tb.sv
